>>> rtl/atan_pkg.sv
// Shared constants, types and the arctangent table for the vector angle block.
package atan_pkg;

    localparam int MagW   = 32;
    localparam int RatioW = 10;
    localparam int AngW   = 18;
    localparam logic [31:0] PhaseReset = 32'd1550960412;
    localparam logic [6:0]  LastIdx    = 7'd100;
    localparam logic [1:0]  AddrPhase  = 2'd0;

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic xzero;
        logic yzero;
        logic xbig;
    } quad_t;

    typedef logic [MagW:0] mag_t;

    function automatic logic [13:0] atan_lut(input logic [6:0] idx);
        logic [13:0] v;
        unique case (idx)
            7'd0: v = 14'd0;      7'd1: v = 14'd209;    7'd2: v = 14'd417;
            7'd3: v = 14'd626;    7'd4: v = 14'd834;    7'd5: v = 14'd1042;
            7'd6: v = 14'd1250;   7'd7: v = 14'd1458;   7'd8: v = 14'd1665;
            7'd9: v = 14'd1872;   7'd10: v = 14'd2079;  7'd11: v = 14'd2285;
            7'd12: v = 14'd2491;  7'd13: v = 14'd2697;  7'd14: v = 14'd2902;
            7'd15: v = 14'd3106;  7'd16: v = 14'd3310;  7'd17: v = 14'd3513;
            7'd18: v = 14'd3715;  7'd19: v = 14'd3917;  7'd20: v = 14'd4118;
            7'd21: v = 14'd4318;  7'd22: v = 14'd4517;  7'd23: v = 14'd4716;
            7'd24: v = 14'd4914;  7'd25: v = 14'd5110;  7'd26: v = 14'd5306;
            7'd27: v = 14'd5501;  7'd28: v = 14'd5695;  7'd29: v = 14'd5888;
            7'd30: v = 14'd6080;  7'd31: v = 14'd6271;  7'd32: v = 14'd6461;
            7'd33: v = 14'd6649;  7'd34: v = 14'd6837;  7'd35: v = 14'd7023;
            7'd36: v = 14'd7209;  7'd37: v = 14'd7393;  7'd38: v = 14'd7576;
            7'd39: v = 14'd7757;  7'd40: v = 14'd7938;  7'd41: v = 14'd8117;
            7'd42: v = 14'd8295;  7'd43: v = 14'd8472;  7'd44: v = 14'd8647;
            7'd45: v = 14'd8821;  7'd46: v = 14'd8994;  7'd47: v = 14'd9165;
            7'd48: v = 14'd9336;  7'd49: v = 14'd9504;  7'd50: v = 14'd9672;
            7'd51: v = 14'd9838;  7'd52: v = 14'd10003; 7'd53: v = 14'd10167;
            7'd54: v = 14'd10329; 7'd55: v = 14'd10490; 7'd56: v = 14'd10649;
            7'd57: v = 14'd10807; 7'd58: v = 14'd10964; 7'd59: v = 14'd11119;
            7'd60: v = 14'd11274; 7'd61: v = 14'd11426; 7'd62: v = 14'd11578;
            7'd63: v = 14'd11728; 7'd64: v = 14'd11876; 7'd65: v = 14'd12024;
            7'd66: v = 14'd12170; 7'd67: v = 14'd12314; 7'd68: v = 14'd12458;
            7'd69: v = 14'd12600; 7'd70: v = 14'd12740; 7'd71: v = 14'd12880;
            7'd72: v = 14'd13018; 7'd73: v = 14'd13154; 7'd74: v = 14'd13290;
            7'd75: v = 14'd13424; 7'd76: v = 14'd13557; 7'd77: v = 14'd13688;
            7'd78: v = 14'd13819; 7'd79: v = 14'd13948; 7'd80: v = 14'd14076;
            7'd81: v = 14'd14202; 7'd82: v = 14'd14328; 7'd83: v = 14'd14452;
            7'd84: v = 14'd14575; 7'd85: v = 14'd14696; 7'd86: v = 14'd14817;
            7'd87: v = 14'd14936; 7'd88: v = 14'd15054; 7'd89: v = 14'd15171;
            7'd90: v = 14'd15287; 7'd91: v = 14'd15402; 7'd92: v = 14'd15515;
            7'd93: v = 14'd15628; 7'd94: v = 14'd15739; 7'd95: v = 14'd15849;
            7'd96: v = 14'd15958; 7'd97: v = 14'd16066; 7'd98: v = 14'd16173;
            7'd99: v = 14'd16279; 7'd100: v = 14'd16383;
            default: v = 14'd16383;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/atan_div.sv
// Pipelined restoring divider giving floor(small*1000/big), one quotient bit per stage.
module atan_div import atan_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  mag_t               small_mag,
    input  mag_t               big,
    input  quad_t              in_quad,
    output logic               out_valid,
    output logic [RatioW:0]    ratio,
    output quad_t              out_quad
);
    localparam int NumW  = MagW + 11;
    localparam int Steps = RatioW + 1;

    logic [Steps:0]          vld_reg;
    logic [NumW-1:0]         rem_reg  [Steps+1];
    mag_t                    big_reg  [Steps+1];
    logic [RatioW:0]         quo_reg  [Steps+1];
    quad_t                   quad_reg [Steps+1];

    logic [NumW-1:0]         num_next;
    assign num_next = NumW'(small_mag) * NumW'(1000);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[Steps-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= num_next;
            big_reg[0]  <= big;
            quo_reg[0]  <= '0;
            quad_reg[0] <= in_quad;
        end
    end

    for (genvar s = 0; s < Steps; s++) begin : g_step
        localparam int Sh = Steps - 1 - s;
        logic [NumW+Steps-1:0] trial;
        logic                  fits;
        assign trial = (NumW+Steps)'(big_reg[s]) << Sh;
        assign fits  = (NumW+Steps)'(rem_reg[s]) >= trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s+1]  <= fits ? rem_reg[s] - NumW'(trial) : rem_reg[s];
                quo_reg[s+1]  <= fits ? (quo_reg[s] | (RatioW+1)'(1 << Sh)) : quo_reg[s];
                big_reg[s+1]  <= big_reg[s];
                quad_reg[s+1] <= quad_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[Steps];
    assign ratio     = quo_reg[Steps];
    assign out_quad  = quad_reg[Steps];
endmodule

>>> rtl/atan_interp.sv
// Table lookup, interpolation and octant fold, two register stages.
module atan_interp import atan_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [RatioW:0]    ratio,
    input  quad_t              quad,
    output logic               out_valid,
    output logic [AngW-1:0]    angle
);
    logic [RatioW:0]  rc;
    logic [17:0]      idx_prod;
    logic [6:0]       idx;
    logic [RatioW:0]  idx_x10;
    logic [3:0]       frac;
    logic [13:0]      lo, hi;
    logic [1:0]       vld_reg;
    logic [13:0]      lo_reg;
    logic [7:0]       diff_reg;
    logic [3:0]       frac_reg;
    quad_t            q_reg;
    logic [11:0]      prod;
    logic [24:0]      prod_scaled;
    logic [AngW-1:0]  a, ang_next, ang_reg;

    always_comb begin
        rc       = (ratio > 11'd1000) ? 11'd1000 : ratio;
        idx_prod = 18'(rc) * 18'd205;
        idx      = idx_prod[17:11];
        idx_x10  = {1'b0, idx, 3'b000} + {3'b000, idx, 1'b0};
        frac     = 4'(rc - idx_x10);
        lo       = atan_lut(idx);
        hi       = (idx < LastIdx) ? atan_lut(idx + 7'd1) : lo;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg   <= lo;
            diff_reg <= 8'(hi - lo);
            frac_reg <= frac;
            q_reg    <= quad;
            ang_reg  <= ang_next;
        end
    end

    always_comb begin
        prod        = {4'b0000, diff_reg} * {8'b0000_0000, frac_reg};
        prod_scaled = {13'b0, prod} * 25'd6554;
        a = AngW'(lo_reg) + AngW'(prod_scaled[24:16]);
        if (q_reg.yzero) begin
            ang_next = (q_reg.xzero || !q_reg.xneg) ? '0 : AngW'(65535);
        end else if (q_reg.xzero) begin
            ang_next = q_reg.yneg ? -AngW'(32767) : AngW'(32767);
        end else if (!q_reg.xneg && !q_reg.yneg) begin
            ang_next = q_reg.xbig ? a : AngW'(32767) - a;
        end else if (q_reg.xneg && !q_reg.yneg) begin
            ang_next = q_reg.xbig ? AngW'(65535) - a : AngW'(32768) + a;
        end else if (q_reg.xneg) begin
            ang_next = q_reg.xbig ? a - AngW'(65535) : -AngW'(32767) - a;
        end else begin
            ang_next = q_reg.xbig ? -a : a - AngW'(32767);
        end
    end

    assign out_valid = vld_reg[1];
    assign angle     = ang_reg;
endmodule

>>> rtl/atan2_lut_interpolated.sv
// Top level of the vector angle block: front end, divider, interpolation, output stage.
// Throughput: one word per cycle while the output is not stalled; the quotient pipeline has 11 stages.
// The whole pipeline advances when the output register is empty or being taken.
// Reset (aresetn low, synchronous) clears all valid bits and sets phase_offset to its default.
// Configuration is by an APB-style port, phase_offset at address 0.
module atan2_lut_interpolated import atan_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // x_component[31:0], y_component[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // angle_q31[31:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0]     phase_reg;
    logic            en;
    logic            fe_vld_reg;
    mag_t            small_reg, big_reg;
    quad_t           quad_reg;
    logic [31:0]     xb, yb;
    mag_t            ax, ay;
    quad_t           q_next;
    logic            dv;
    logic [RatioW:0] ratio;
    quad_t           dq;
    logic            iv;
    logic [AngW-1:0] ang;
    logic            out_vld_reg;
    logic [31:0]     out_reg;

    assign pready   = 1'b1;
    assign prdata   = (paddr == AddrPhase) ? phase_reg : '0;
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PhaseReset;
        end else if (psel && penable && pwrite && paddr == AddrPhase) begin
            phase_reg <= pwdata;
        end
    end

    always_comb begin
        xb = s_tdata[31:0];
        yb = s_tdata[63:32];
        ax = xb[31] ? mag_t'(-{1'b1, xb}) : mag_t'(xb);
        ay = yb[31] ? mag_t'(-{1'b1, yb}) : mag_t'(yb);
        q_next.xneg  = xb[31];
        q_next.yneg  = yb[31];
        q_next.xzero = (xb == '0);
        q_next.yzero = (yb == '0);
        q_next.xbig  = ax > ay;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fe_vld_reg <= 1'b0;
        end else if (en) begin
            fe_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            small_reg <= q_next.xbig ? ay : ax;
            big_reg   <= q_next.xbig ? ax : ay;
            quad_reg  <= q_next;
        end
    end

    atan_div u_div (
        .aclk, .aresetn, .en,
        .in_valid (fe_vld_reg),
        .small_mag(small_reg),
        .big      (big_reg),
        .in_quad  (quad_reg),
        .out_valid(dv),
        .ratio,
        .out_quad (dq)
    );

    atan_interp u_interp (
        .aclk, .aresetn, .en,
        .in_valid (dv),
        .ratio,
        .quad     (dq),
        .out_valid(iv),
        .angle    (ang)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= iv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= {ang[16:0], 15'd0} + phase_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;
endmodule

>>> rtl/atan_checker.sv
// Port-level checks for the vector angle block, bound to the top level.
module atan_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        pready
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word dropped or changed under stall");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");
endmodule

bind atan2_lut_interpolated atan_checker u_atan_checker (
    .aclk, .aresetn, .s_tready, .m_tvalid, .m_tready, .m_tdata, .pready
);
